// ===== src/chcw_pkg.sv =====
// ----------------------------------------------------------------------------
// chcw_pkg
// Shared types, constants and the control store of the census cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package chcw_pkg;

	localparam int ROW_CAP_DEFAULT   = 1024;
	localparam int CODE_BITS_DEFAULT = 32;
	localparam int MAX_DISPARITY     = 64;
	localparam int SCALE_TOP         = 255;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// divider: best disparity times the scale top, over max_disp clamped to MAX_DISPARITY
	localparam int NUM_W = 14;
	localparam int QUO_W = 8;
	localparam int CNT_W = $clog2(NUM_W);

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_WINDOW_SIZE       = 3'd0;
	localparam reg_idx_t REG_MIN_DISP          = 3'd1;
	localparam reg_idx_t REG_MAX_DISP          = 3'd2;
	localparam reg_idx_t REG_IMAGE_WIDTH       = 3'd3;
	localparam reg_idx_t REG_REFERENCE_IS_LEFT = 3'd4;

	typedef struct packed {
		logic [2:0]  window_size;
		logic [5:0]  min_disp;
		logic [6:0]  max_disp;
		logic [10:0] image_width;
		logic        reference_is_left;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		window_size:       3'd5,
		min_disp:          6'd0,
		max_disp:          7'd64,
		image_width:       11'd1024,
		reference_is_left: 1'b1
	};

	localparam logic [5:0] MIN_COST_RESET = 6'd26;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_MATCH = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [9:0]  column;
		logic [31:0] census_word;
	} item_t;

	typedef struct packed {
		logic       valid_res;
		logic [5:0] disparity;
		logic [5:0] cost;
		logic       last;
		logic [5:0] best_disparity;
		logic [7:0] scaled_disparity;
	} res_t;

	// control store
	typedef logic [2:0] pc_t;
	localparam pc_t PC_FETCH    = 3'd0;
	localparam pc_t PC_CHECK    = 3'd1;
	localparam pc_t PC_LOOP     = 3'd2;
	localparam pc_t PC_DIV_INIT = 3'd3;
	localparam pc_t PC_DIV      = 3'd4;
	localparam pc_t PC_LAST     = 3'd5;
	localparam pc_t PC_INVAL    = 3'd6;

	typedef enum logic [2:0] {
		A_NONE,
		A_ACCEPT,
		A_CHECK,
		A_LOOP,
		A_DIV_INIT,
		A_DIV,
		A_EMIT_LAST,
		A_EMIT_INVAL
	} act_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_MATCH,
		C_BAD,
		C_LOOP_DONE,
		C_DIV_DONE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  stay;
		pc_t   target;
	} ctrl_word_t;

	typedef struct packed {
		logic match;
		logic bad;
		logic loop_done;
		logic div_done;
		logic out_free;
	} status_t;

	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t w;
		case (pc)
			PC_FETCH:    w = '{A_ACCEPT,     C_MATCH,     1'b1, PC_CHECK};
			PC_CHECK:    w = '{A_CHECK,      C_BAD,       1'b0, PC_INVAL};
			PC_LOOP:     w = '{A_LOOP,       C_LOOP_DONE, 1'b1, PC_DIV_INIT};
			PC_DIV_INIT: w = '{A_DIV_INIT,   C_ALWAYS,    1'b0, PC_DIV};
			PC_DIV:      w = '{A_DIV,        C_DIV_DONE,  1'b1, PC_LAST};
			PC_LAST:     w = '{A_EMIT_LAST,  C_OUT_FREE,  1'b1, PC_FETCH};
			PC_INVAL:    w = '{A_EMIT_INVAL, C_OUT_FREE,  1'b1, PC_FETCH};
			default:     w = '{A_NONE,       C_ALWAYS,    1'b0, PC_FETCH};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== src/chcw_seq.sv =====
// ----------------------------------------------------------------------------
// chcw_seq
// Step counter over the control store, with conditional jumps on status.
// ----------------------------------------------------------------------------
`default_nettype none

module chcw_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  chcw_pkg::status_t      status,
	output chcw_pkg::ctrl_word_t   ctrl
);
	import chcw_pkg::*;

	pc_t  pc_q;
	pc_t  pc_nx;
	logic cond_ok;

	always_comb begin
		ctrl = ucode(pc_q);
	end

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:    cond_ok = 1'b1;
			C_MATCH:     cond_ok = status.match;
			C_BAD:       cond_ok = status.bad;
			C_LOOP_DONE: cond_ok = status.loop_done;
			C_DIV_DONE:  cond_ok = status.div_done;
			C_OUT_FREE:  cond_ok = status.out_free;
			default:     cond_ok = 1'b1;
		endcase
		if (cond_ok) begin
			pc_nx = ctrl.target;
		end else if (ctrl.stay) begin
			pc_nx = pc_q;
		end else begin
			pc_nx = pc_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else begin
			pc_q <= pc_nx;
		end
	end

endmodule

`default_nettype wire

// ===== src/chcw_div.sv =====
// ----------------------------------------------------------------------------
// chcw_div
// Restoring divider, one quotient bit a step, for the scaled disparity.
// ----------------------------------------------------------------------------
`default_nettype none

module chcw_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        step,
	input  logic [5:0]                  best,
	input  logic [6:0]                  divisor,
	output logic                        done,
	output logic [chcw_pkg::QUO_W-1:0]  quotient
);
	import chcw_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [6:0]       rem_q;
	logic [6:0]       div_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rem_sh;
	logic             ge;
	logic [7:0]       rem_nx;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	assign done     = step && (cnt_q == CNT_W'(NUM_W - 1));
	assign quotient = num_q[QUO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(best) * NUM_W'(SCALE_TOP);
			rem_q <= '0;
			div_q <= divisor;
		end else if (step) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx[6:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/chcw_dp.sv =====
// ----------------------------------------------------------------------------
// chcw_dp
// Row store, range check, Hamming cost, running minimum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chcw_dp #(
	parameter int ROW_CAPACITY = chcw_pkg::ROW_CAP_DEFAULT,
	parameter int CODE_BITS    = chcw_pkg::CODE_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chcw_pkg::cfg_t              cfg,
	input  chcw_pkg::ctrl_word_t        ctrl,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  chcw_pkg::item_t             item_data,
	output logic                        res_valid,
	input  logic                        res_stall,
	output chcw_pkg::res_t              res_data,
	input  logic [chcw_pkg::QUO_W-1:0]  quotient,
	input  logic                        div_done,
	output logic [5:0]                  best,
	output logic [6:0]                  maxd,
	output chcw_pkg::status_t           status
);
	import chcw_pkg::*;

	localparam int AW = $clog2(ROW_CAPACITY);
	localparam int IW = (AW > 11) ? AW : 11;

	logic [CODE_BITS-1:0] mem [ROW_CAPACITY];

	logic [CODE_BITS-1:0] word_q;
	logic [9:0]           col_q;
	logic [6:0]           d_q;
	logic                 issue_done_q;
	logic                 rd_vld_s1;
	logic [6:0]           rd_d_s1;
	logic [CODE_BITS-1:0] rdata_s1;
	logic [5:0]           min_q;
	logic [5:0]           best_q;
	logic [5:0]           last_cost_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic                 accept;
	logic                 wr_en;
	logic [IW-1:0]        wr_ext;
	logic [IW-1:0]        idx;
	logic [10:0]          width_eff;
	logic                 bad;
	logic signed [13:0]   col_s;
	logic signed [13:0]   mind_s;
	logic signed [13:0]   maxd_s;
	logic signed [13:0]   h_s;
	logic signed [13:0]   width_s;
	logic signed [13:0]   mdh_s;
	logic signed [13:0]   beg_s;
	logic signed [13:0]   end_s;
	logic                 out_free;
	logic                 adv;
	logic                 issue;
	logic                 rd_last;
	logic                 loop_done;
	logic [5:0]           cost;
	logic                 emit_loop;
	logic                 emit_last;
	logic                 emit_inval;
	logic                 emit;
	res_t                 res_nx;

	function automatic logic [5:0] popcnt(input logic [CODE_BITS-1:0] v);
		logic [31:0] w;
		logic [3:0]  grp [4];
		logic [5:0]  sum;
		w = 32'(v);
		for (int g = 0; g < 4; g++) begin
			grp[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp[g] = grp[g] + 4'(w[8*g+b]);
			end
		end
		sum = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]);
		return sum;
	endfunction

	// input side
	assign item_stall = (ctrl.act != A_ACCEPT);
	assign accept     = item_valid && (ctrl.act == A_ACCEPT);
	assign wr_ext     = IW'(item_data.column);
	assign wr_en      = accept && (item_data.mode == MODE_LOAD)
		&& (32'(item_data.column) < ROW_CAPACITY);

	// clamped registers and valid column range
	always_comb begin
		maxd = (32'(cfg.max_disp) > MAX_DISPARITY) ? 7'(MAX_DISPARITY) : cfg.max_disp;
		width_eff = (32'(cfg.image_width) > ROW_CAPACITY) ? 11'(ROW_CAPACITY)
			: cfg.image_width;
		col_s   = 14'(col_q);
		mind_s  = 14'(cfg.min_disp);
		maxd_s  = 14'(maxd);
		h_s     = 14'(cfg.window_size[2:1]);
		width_s = 14'(width_eff);
		mdh_s   = mind_s - h_s;
		if (cfg.reference_is_left) begin
			beg_s = maxd_s + h_s;
			end_s = width_s + ((mdh_s > 14'sd0) ? 14'sd0 : mdh_s);
		end else begin
			beg_s = h_s;
			end_s = width_s - maxd_s - h_s;
		end
		bad = ({1'b0, cfg.min_disp} >= maxd) || (col_s < beg_s) || (col_s >= end_s);
	end

	// disparity loop
	assign out_free  = !res_valid_q || !res_stall;
	assign adv       = (ctrl.act == A_LOOP) && out_free;
	assign issue     = adv && !issue_done_q;
	assign rd_last   = (rd_d_s1 == (maxd - 7'd1));
	assign loop_done = adv && rd_vld_s1 && rd_last;
	assign idx       = cfg.reference_is_left ? (IW'(col_q) - IW'(d_q))
		: (IW'(col_q) + IW'(d_q));
	assign cost      = popcnt(word_q ^ rdata_s1);

	assign emit_loop  = adv && rd_vld_s1 && !rd_last;
	assign emit_last  = (ctrl.act == A_EMIT_LAST) && out_free;
	assign emit_inval = (ctrl.act == A_EMIT_INVAL) && out_free;
	assign emit       = emit_loop || emit_last || emit_inval;

	always_comb begin
		res_nx = '0;
		if (emit_loop) begin
			res_nx.valid_res = 1'b1;
			res_nx.disparity = rd_d_s1[5:0];
			res_nx.cost      = cost;
		end else if (emit_last) begin
			res_nx.valid_res        = 1'b1;
			res_nx.disparity        = 6'(maxd - 7'd1);
			res_nx.cost             = last_cost_q;
			res_nx.last             = 1'b1;
			res_nx.best_disparity   = best_q;
			res_nx.scaled_disparity = quotient;
		end else begin
			res_nx.last = 1'b1;
		end
	end

	assign status = '{
		match:     accept && (item_data.mode == MODE_MATCH),
		bad:       bad,
		loop_done: loop_done,
		div_done:  div_done,
		out_free:  out_free
	};

	assign best      = best_q;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// row store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ext[AW-1:0]] <= item_data.census_word[CODE_BITS-1:0];
		end
		if (issue) begin
			rdata_s1 <= mem[idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q          <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			min_q        <= MIN_COST_RESET;
			best_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if ((ctrl.act == A_CHECK) && !bad) begin
				d_q          <= {1'b0, cfg.min_disp};
				issue_done_q <= 1'b0;
				rd_vld_s1    <= 1'b0;
				min_q        <= 6'({3'd0, cfg.window_size} * {3'd0, cfg.window_size}) + 6'd1;
				best_q       <= '0;
			end else if (adv) begin
				if (!issue_done_q) begin
					rd_vld_s1 <= 1'b1;
					d_q       <= d_q + 7'd1;
					if (d_q == (maxd - 7'd1)) begin
						issue_done_q <= 1'b1;
					end
				end else begin
					rd_vld_s1 <= 1'b0;
				end
				if (rd_vld_s1 && (cost < min_q)) begin
					min_q  <= cost;
					best_q <= rd_d_s1[5:0];
				end
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= item_data.census_word[CODE_BITS-1:0];
			col_q  <= item_data.column;
		end
		if (issue) begin
			rd_d_s1 <= d_q;
		end
		if (loop_done) begin
			last_cost_q <= cost;
		end
		if (emit) begin
			res_q <= res_nx;
		end
	end

endmodule

`default_nettype wire

// ===== src/census_hamming_cost_wta.sv =====
// ----------------------------------------------------------------------------
// census_hamming_cost_wta
// Census Hamming matching cost over one image row, winner-takes-all disparity.
// ----------------------------------------------------------------------------
// item channel: a load word (mode 0) writes a right census word into the row
//   store; the next word is taken in the following cycle
// a match word (mode 1) goes through a check step, the disparity loop (one row
//   store read and one cost a cycle while the output register is free), a
//   bit-serial divider for the scaled disparity, then the last result word
// an out-of-range column or empty disparity range gives one invalid, last
//   word after the check step
// res channel: one output register; while res_stall holds a valid word the loop
//   halts and the word holds; item_stall stays high until a match has finished
// apb port: five 32-bit registers at byte offsets 0 to 16, to be written only
//   while idle; the block itself does not enforce this
// reset: sequencer back to fetch, registers to defaults, no output word;
//   the row store is not cleared and reads as unknown until written
// ----------------------------------------------------------------------------
`default_nettype none

module census_hamming_cost_wta #(
	parameter int ROW_CAPACITY = chcw_pkg::ROW_CAP_DEFAULT,
	parameter int CODE_BITS    = chcw_pkg::CODE_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  chcw_pkg::item_t                item_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output chcw_pkg::res_t                 res_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chcw_pkg::PADDR_W-1:0]   paddr,
	input  logic [chcw_pkg::PDATA_W-1:0]   pwdata,
	output logic [chcw_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import chcw_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;
	ctrl_word_t ctrl;
	status_t    status;
	logic [5:0] best;
	logic [6:0] maxd;
	logic       div_done;
	logic [QUO_W-1:0] quotient;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WINDOW_SIZE:       cfg_q.window_size       <= pwdata[2:0];
				REG_MIN_DISP:          cfg_q.min_disp          <= pwdata[5:0];
				REG_MAX_DISP:          cfg_q.max_disp          <= pwdata[6:0];
				REG_IMAGE_WIDTH:       cfg_q.image_width       <= pwdata[10:0];
				REG_REFERENCE_IS_LEFT: cfg_q.reference_is_left <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_SIZE:       prdata = PDATA_W'(cfg_q.window_size);
			REG_MIN_DISP:          prdata = PDATA_W'(cfg_q.min_disp);
			REG_MAX_DISP:          prdata = PDATA_W'(cfg_q.max_disp);
			REG_IMAGE_WIDTH:       prdata = PDATA_W'(cfg_q.image_width);
			REG_REFERENCE_IS_LEFT: prdata = PDATA_W'(cfg_q.reference_is_left);
			default:               prdata = '0;
		endcase
	end

	chcw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	chcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.act == A_DIV_INIT),
		.step     (ctrl.act == A_DIV),
		.best     (best),
		.divisor  (maxd),
		.done     (div_done),
		.quotient (quotient)
	);

	chcw_dp #(
		.ROW_CAPACITY (ROW_CAPACITY),
		.CODE_BITS    (CODE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.ctrl       (ctrl),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.quotient   (quotient),
		.div_done   (div_done),
		.best       (best),
		.maxd       (maxd),
		.status     (status)
	);

endmodule

`default_nettype wire

// ===== src/chcw_chk.sv =====
// ----------------------------------------------------------------------------
// chcw_chk
// Port-level checks on the census cost block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chcw_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input chcw_pkg::item_t  item_data,
	input logic             res_valid,
	input logic             res_stall,
	input chcw_pkg::res_t   res_data
);
	import chcw_pkg::*;

	// held word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result word changed while stalled");

	// a match keeps the input closed in the next cycle
	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item_data.mode == MODE_MATCH) |=> item_stall)
		else $error("input open straight after a match word");

	// invalid word is a bare last marker
	a_inval_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.valid_res |-> res_data.last && (res_data.cost == 6'd0)
			&& (res_data.disparity == 6'd0) && (res_data.scaled_disparity == 8'd0))
		else $error("malformed invalid result word");

	// intermediate cost words carry no winner
	a_mid_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> res_data.valid_res
			&& (res_data.best_disparity == 6'd0) && (res_data.scaled_disparity == 8'd0))
		else $error("winner fields set on an intermediate word");

endmodule

bind census_hamming_cost_wta chcw_chk u_chk (.*);

`default_nettype wire

// ===== tb/census_hamming_cost_wta_tb.sv =====
// ----------------------------------------------------------------------------
// census_hamming_cost_wta_tb
// Self-checking bench for the census Hamming cost and winner-takes-all block.
// Load words fill a row model and match words are predicted to one cost word
// per disparity plus the best and scaled disparity. Results are checked in
// order against the predicted queue. Directed corners come first, then random
// traffic under varying configuration, idling on both channels and a long
// receiver hold-off.
// ----------------------------------------------------------------------------

module census_hamming_cost_wta_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chcw_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int REPORT_CAP    = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item_data;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	census_hamming_cost_wta dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// row model, configuration copy and predicted cost words
	logic [31:0] right_row [ROW_CAP_DEFAULT];
	bit          right_written [ROW_CAP_DEFAULT];
	cfg_t        cur_cfg = CFG_RESET;
	res_t        expected_costs [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int holds_served;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	res_t exp_word;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int eff_max();
		return (cur_cfg.max_disp > MAX_DISPARITY) ? MAX_DISPARITY : int'(cur_cfg.max_disp);
	endfunction

	function automatic int eff_width();
		return (cur_cfg.image_width > ROW_CAP_DEFAULT) ? ROW_CAP_DEFAULT :
			int'(cur_cfg.image_width);
	endfunction

	function automatic int col_lo();
		int h;
		h = cur_cfg.window_size / 2;
		return cur_cfg.reference_is_left ? eff_max() + h : h;
	endfunction

	function automatic int col_hi();
		int h;
		int slack;
		h = cur_cfg.window_size / 2;
		slack = int'(cur_cfg.min_disp) - h;
		if (cur_cfg.reference_is_left)
			return eff_width() + ((slack > 0) ? 0 : slack);
		return eff_width() - eff_max() - h;
	endfunction

	function automatic bit column_ok(input int col);
		return int'(cur_cfg.min_disp) < eff_max() && col >= col_lo() && col < col_hi();
	endfunction

	function automatic int ref_col(input int col, input int d);
		return cur_cfg.reference_is_left ? col - d : col + d;
	endfunction

	function automatic void predict_costs(input item_t w);
		res_t r;
		int   ws;
		int   best_cost;
		int   best_d;
		int   cost;
		int   maxd;
		maxd = eff_max();
		r = '0;
		if (!column_ok(w.column)) begin
			r.last = 1'b1;
			expected_costs.push_back(r);
			return;
		end
		ws = cur_cfg.window_size;
		best_cost = ws * ws + 1;
		best_d = 0;
		for (int d = cur_cfg.min_disp; d < maxd; d++) begin
			cost = $countones(w.census_word ^ right_row[ref_col(w.column, d)]);
			if (cost < best_cost) begin
				best_cost = cost;
				best_d = d;
			end
			r = '0;
			r.valid_res = 1'b1;
			r.disparity = d;
			r.cost = cost;
			if (d == maxd - 1) begin
				r.last = 1'b1;
				r.best_disparity = best_d;
				r.scaled_disparity = best_d * SCALE_TOP / maxd;
			end
			expected_costs.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// item channel
	// ------------------------------------------------------------------
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (w.mode == MODE_LOAD) begin
			right_row[w.column] = w.census_word;
			right_written[w.column] = 1'b1;
		end else begin
			predict_costs(w);
		end
	endtask

	task automatic load_word(input int col, input logic [31:0] cw);
		item_t w;
		w.mode = MODE_LOAD;
		w.column = col;
		w.census_word = cw;
		send_word(w);
	endtask

	// make sure every row entry the match will read has been loaded
	task automatic fill_for(input int col);
		int idx;
		if (!column_ok(col))
			return;
		for (int d = cur_cfg.min_disp; d < eff_max(); d++) begin
			idx = ref_col(col, d);
			if (!right_written[idx])
				load_word(idx, $urandom());
		end
	endtask

	// match word built from the stored word at disparity d with some bits flipped
	task automatic match_at(input int col, input int d, input logic [31:0] flips);
		item_t w;
		fill_for(col);
		w.mode = MODE_MATCH;
		w.column = col;
		w.census_word = column_ok(col) ? right_row[ref_col(col, d)] ^ flips : flips;
		send_word(w);
	endtask

	function automatic logic [31:0] sparse_mask();
		logic [31:0] m;
		m = '0;
		repeat ($urandom_range(3)) m[$urandom_range(31)] = 1'b1;
		return m;
	endfunction

	task automatic random_match(input int col);
		logic [31:0] m;
		int          d;
		m = ($urandom_range(3) == 0) ? $urandom() : sparse_mask();
		d = column_ok(col) ? $urandom_range(eff_max() - 1, cur_cfg.min_disp) : 0;
		match_at(col, d, m);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_costs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_cfg(input int ws, input int mind, input int maxd, input int wid,
			input bit left);
		apb_write(REG_WINDOW_SIZE, ws);
		apb_write(REG_MIN_DISP, mind);
		apb_write(REG_MAX_DISP, maxd);
		apb_write(REG_IMAGE_WIDTH, wid);
		apb_write(REG_REFERENCE_IS_LEFT, left);
		cur_cfg.window_size = ws;
		cur_cfg.min_disp = mind;
		cur_cfg.max_disp = maxd;
		cur_cfg.image_width = wid;
		cur_cfg.reference_is_left = left;
	endtask

	task automatic pick_random_cfg();
		int sel;
		int maxd;
		int eff;
		int mind;
		int wid;
		sel = $urandom_range(9);
		maxd = (sel == 0) ? $urandom_range(127, 65) : (sel == 1) ? 1 :
			(sel == 2) ? 64 : $urandom_range(64, 2);
		eff = (maxd > MAX_DISPARITY) ? MAX_DISPARITY : maxd;
		sel = $urandom_range(9);
		if (sel == 0 && eff <= 63)
			mind = $urandom_range(63, eff);
		else if (sel == 1)
			mind = 0;
		else
			mind = eff - $urandom_range((eff < 16) ? eff : 16, 1);
		sel = $urandom_range(9);
		wid = (sel == 0) ? $urandom_range(2047, 1025) : (sel == 1) ? $urandom_range(80, 1) :
			$urandom_range(1024, 200);
		set_cfg($urandom_range(5, 1), mind, maxd, wid, $urandom_range(1));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_config();
		load_word(0, 32'h0000_0000);
		load_word(1023, 32'hFFFF_FFFF);
		match_at(66, 40, 32'h0);
		match_at(1021, 63, 32'h0);
		match_at(700, 10, 32'hFFFF_FFFF);
		match_at(65, 0, 32'h0);
		match_at(1022, 0, 32'hFFFF_FFFF);
		match_at(1023, 0, 32'h0);
		match_at(0, 0, 32'hFFFF_FFFF);
	endtask

	task automatic test_config_corners();
		// right reference, single disparity, one-pixel window
		wait_idle();
		set_cfg(1, 0, 1, 16, 1'b0);
		match_at(0, 0, 32'h0);
		match_at(14, 0, 32'h1);
		match_at(5, 0, 32'h3);
		match_at(15, 0, 32'h0);
		// empty disparity range
		wait_idle();
		set_cfg(5, 10, 10, 1024, 1'b1);
		match_at(500, 0, 32'h0);
		// top disparity only
		wait_idle();
		set_cfg(3, 63, 64, 1024, 1'b1);
		match_at(1023, 63, 32'hFFFF_FFFF);
		match_at(65, 63, 32'h0);
		match_at(64, 63, 32'h0);
		// oversized max_disp and image_width
		wait_idle();
		set_cfg(4, 0, 100, 1500, 1'b0);
		match_at(957, 20, 32'h0);
		match_at(2, 5, 32'h1);
		match_at(958, 0, 32'h0);
		// one-pixel row leaves no valid column
		wait_idle();
		set_cfg(2, 3, 64, 1, 1'b1);
		match_at(0, 0, 32'h0);
	endtask

	task automatic test_traffic(input int tx_idle, input int rx_stall, input int n);
		int sel;
		send_idle_pct = tx_idle;
		recv_stall_pct = rx_stall;
		for (int i = 0; i < n; i++) begin
			if (i % 12 == 0) begin
				wait_idle();
				pick_random_cfg();
			end
			sel = $urandom_range(99);
			if (sel < 20)
				load_word($urandom_range(1023), $urandom());
			else if (sel < 85 && col_hi() > col_lo())
				random_match($urandom_range(col_hi() - 1, col_lo()));
			else
				random_match($urandom_range(1023));
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		set_cfg(3, 0, 16, 512, 1'b1);
		hold_requests++;
		repeat (10) random_match($urandom_range(col_hi() - 1, col_lo()));
	endtask

	// ------------------------------------------------------------------
	// receiver, result check and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_costs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$error("result word with nothing expected");
			end else begin
				exp_word = expected_costs.pop_front();
				check_field("valid_res", exp_word.valid_res, res_data.valid_res);
				check_field("disparity", exp_word.disparity, res_data.disparity);
				check_field("cost", exp_word.cost, res_data.cost);
				check_field("last", exp_word.last, res_data.last);
				check_field("best_disparity", exp_word.best_disparity,
					res_data.best_disparity);
				check_field("scaled_disparity", exp_word.scaled_disparity,
					res_data.scaled_disparity);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_config_corners();
		test_traffic(23, 71, 32);
		test_traffic(71, 23, 32);
		test_traffic(0, 0, 32);
		test_backpressure();

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_costs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== census_hamming_cost_wta.f =====
src/chcw_pkg.sv
src/chcw_seq.sv
src/chcw_div.sv
src/chcw_dp.sv
src/census_hamming_cost_wta.sv
src/chcw_chk.sv
tb/census_hamming_cost_wta_tb.sv
